/* sv/pts_pkg.sv */
// Shared types and constants for the priority task scheduler.
// No dependencies; used by every module of the block.
`default_nettype none
package pts_pkg;
	localparam int NumLevels = 32;
	localparam int NumTasks  = 16;
	localparam int LvlW      = $clog2(NumLevels);
	localparam int TaskW     = $clog2(NumTasks);
	localparam logic [7:0] LockMax = 8'd255;
	localparam int QDepth    = 2;

	typedef enum logic [2:0] {
		OP_READY    = 3'd0,
		OP_UNREADY  = 3'd1,
		OP_DELAY    = 3'd2,
		OP_UNDELAY  = 3'd3,
		OP_TICK     = 3'd4,
		OP_LOCK     = 3'd5,
		OP_UNLOCK   = 3'd6,
		OP_SCHEDULE = 3'd7
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             tid_ok;
		logic [TaskW-1:0] tid;
		logic [LvlW-1:0]  lvl;
		logic [31:0]      dticks;
	} cmd_t;

	typedef struct packed {
		logic              switch_now;
		logic [TaskW-1:0]  next_task;
		logic [15:0]       woken_mask;
		logic [7:0]        lock_level;
		logic [31:0]       tick_total;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RM_WALK,
		ST_PUSH_HEAD,
		ST_TICK_SCAN,
		ST_SLICE,
		ST_SLICE_PUSH,
		ST_SCHED,
		ST_DONE
	} st_t;
endpackage
`default_nettype wire

/* sv/priority_task_scheduler_unit.sv */
// Top level of the priority task scheduler: front end, command queue and
// sequencing engine. Uses pts_pkg, pts_front and pts_engine.
// A tick walks all 16 delay counters one per cycle, pausing to move each
// woken task, and each FIFO removal walks one link per cycle. A result waits
// in an output register while up to two further items queue at the front.
`default_nettype none
module priority_task_scheduler_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  op,
	input  wire logic [3:0]  task_id,
	input  wire logic [4:0]  prio,
	input  wire logic [31:0] delay_ticks,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  slice_length,
	output logic             empty,
	input  wire logic        pop,
	output logic             switch_now,
	output logic [3:0]       next_task,
	output logic [15:0]      woken_mask,
	output logic [7:0]       lock_level,
	output logic [31:0]      tick_total
);
	import pts_pkg::*;

	cmd_t cmd;
	res_t res;
	logic cmd_valid, cmd_take, res_valid;

	pts_front u_front (
		.clk, .arst_n, .push, .full, .op, .task_id, .prio, .delay_ticks,
		.cmd, .cmd_valid, .cmd_take
	);

	pts_engine u_engine (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_take,
		.cfg_we, .cfg_wdata(slice_length),
		.res, .res_valid, .res_take(pop)
	);

	assign empty      = !res_valid;
	assign switch_now = res.switch_now;
	assign next_task  = res.next_task;
	assign woken_mask = res.woken_mask;
	assign lock_level = res.lock_level;
	assign tick_total = res.tick_total;
endmodule
`default_nettype wire

/* sv/pts_front.sv */
// Front end: accepts items, range-checks the task id, clamps the level and
// normalises the delay, then queues the command for the engine. Uses pts_pkg.
`default_nettype none
module pts_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic [2:0]    op,
	input  wire logic [3:0]    task_id,
	input  wire logic [4:0]    prio,
	input  wire logic [31:0]   delay_ticks,
	output pts_pkg::cmd_t      cmd,
	output logic               cmd_valid,
	input  wire logic          cmd_take
);
	import pts_pkg::*;

	cmd_t q_q [QDepth];
	logic [$clog2(QDepth)-1:0] wp_q, rp_q;
	logic [$clog2(QDepth):0]   cnt_q;
	cmd_t c;
	logic acc, take;

	always_comb begin
		c.op     = op_t'(op);
		c.tid_ok = 32'(task_id) < NumTasks;
		c.tid    = TaskW'(task_id);
		c.lvl    = (32'(prio) < NumLevels) ? LvlW'(prio) : LvlW'(NumLevels - 1);
		c.dticks = (delay_ticks == 32'd0) ? 32'd1 : delay_ticks;
	end

	assign full      = cnt_q == ($clog2(QDepth)+1)'(QDepth);
	assign cmd_valid = cnt_q != '0;
	assign cmd       = q_q[rp_q];
	assign acc       = push && !full;
	assign take      = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (acc) q_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (acc) wp_q <= wp_q + 1'b1;
			if (take) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + ($clog2(QDepth)+1)'(acc) - ($clog2(QDepth)+1)'(take);
		end
	end
endmodule
`default_nettype wire

/* sv/pts_engine.sv */
// Back end: sequencer that carries out one command at a time, stepping through
// states that work on the level FIFOs, delay counters and slices. Uses pts_pkg.
`default_nettype none
module pts_engine (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  pts_pkg::cmd_t      cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_take,
	input  wire logic          cfg_we,
	input  wire logic [7:0]    cfg_wdata,
	output pts_pkg::res_t      res,
	output logic               res_valid,
	input  wire logic          res_take
);
	import pts_pkg::*;

	logic [NumLevels-1:0]  ready_q;
	logic [TaskW-1:0]      head_q [NumLevels];
	logic [TaskW-1:0]      tail_q [NumLevels];
	logic [TaskW:0]        count_q [NumLevels];
	logic [TaskW-1:0]      link_q [NumTasks];
	logic [LvlW-1:0]       level_q [NumTasks];
	logic [31:0]           dleft_q [NumTasks];
	logic [NumTasks-1:0]   dflag_q;
	logic [7:0]            slice_q [NumTasks];
	logic [7:0]            lock_q, slen_q;
	logic [TaskW-1:0]      run_q;
	logic                  runv_q;
	logic [31:0]           ticks_q;

	st_t st_q, st_d;
	cmd_t cmd_q;
	logic [TaskW-1:0]  tsk_q, cur_q, prev_q, scan_q;
	logic              hasp_q, found_q, wake_q;
	logic [LvlW-1:0]   rl_q, nl_q;
	logic [TaskW:0]    i_q;
	logic [15:0]       woken_q;
	logic              sw_q;
	res_t              out_q;
	logic              outv_q;

	// priority encoder over the ready bitmap
	logic [LvlW-1:0] top_lvl;
	always_comb begin
		top_lvl = '0;
		for (int l = NumLevels-1; l >= 0; l--)
			if (ready_q[l]) top_lvl = LvlW'(l);
	end

	assign cmd_take  = (st_q == ST_IDLE) && cmd_valid && !outv_q;
	assign res       = out_q;
	assign res_valid = outv_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (cmd_take) st_d = ST_DONE;
			default:  st_d = st_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && cmd_take) cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ready_q <= '0; dflag_q <= '0; lock_q <= '0; run_q <= '0;
			runv_q <= 1'b0; ticks_q <= '0; slen_q <= 8'd10; outv_q <= 1'b0;
			for (int l = 0; l < NumLevels; l++) count_q[l] <= '0;
			for (int t = 0; t < NumTasks; t++) slice_q[t] <= '0;
			// a task never readied is looked up on level 0, where it is never found
			for (int t = 0; t < NumTasks; t++) level_q[t] <= '0;
			tsk_q <= '0; cur_q <= '0; prev_q <= '0; scan_q <= '0; hasp_q <= 1'b0;
			found_q <= 1'b0; wake_q <= 1'b0; rl_q <= '0; nl_q <= '0; i_q <= '0;
			woken_q <= '0; sw_q <= 1'b0; out_q <= '0;
		end else begin
			if (cfg_we) slen_q <= cfg_wdata;
			if (res_take && outv_q) outv_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (cmd_take) begin
					woken_q <= '0; sw_q <= 1'b0; wake_q <= 1'b0;
					tsk_q <= cmd.tid; nl_q <= cmd.lvl;
					rl_q <= level_q[cmd.tid]; cur_q <= head_q[level_q[cmd.tid]];
					hasp_q <= 1'b0; i_q <= '0; found_q <= 1'b0;
					unique case (cmd.op)
						OP_READY, OP_UNREADY:
							st_q <= cmd.tid_ok ? ST_RM_WALK : ST_DONE;
						OP_DELAY: begin
							if (cmd.tid_ok) begin
								dleft_q[cmd.tid] <= cmd.dticks;
								dflag_q[cmd.tid] <= 1'b1;
							end
							st_q <= ST_DONE;
						end
						OP_UNDELAY: begin
							if (cmd.tid_ok) dflag_q[cmd.tid] <= 1'b0;
							st_q <= ST_DONE;
						end
						OP_TICK: begin
							scan_q <= '0;
							ticks_q <= ticks_q + 32'd1;
							st_q <= ST_TICK_SCAN;
						end
						OP_LOCK: begin
							if (lock_q != LockMax) lock_q <= lock_q + 8'd1;
							st_q <= ST_DONE;
						end
						OP_UNLOCK: begin
							if (lock_q != '0) lock_q <= lock_q - 8'd1;
							st_q <= (lock_q == 8'd1) ? ST_SCHED : ST_DONE;
						end
						OP_SCHEDULE: st_q <= ST_SCHED;
						default: st_q <= ST_DONE;
					endcase
				end
				// one FIFO link per cycle; removes tsk_q from level rl_q
				ST_RM_WALK: begin
					if (i_q >= count_q[rl_q]) begin
						found_q <= 1'b0;
						st_q <= wake_q ? ST_PUSH_HEAD :
							(cmd_q.op == OP_READY) ? ST_PUSH_HEAD :
							(cmd_q.op == OP_TICK) ? ST_SLICE_PUSH : ST_DONE;
					end else if (cur_q == tsk_q) begin
						if (hasp_q) link_q[prev_q] <= link_q[cur_q];
						else head_q[rl_q] <= link_q[cur_q];
						if (tail_q[rl_q] == tsk_q && hasp_q) tail_q[rl_q] <= prev_q;
						count_q[rl_q] <= count_q[rl_q] - 1'b1;
						if (count_q[rl_q] == (TaskW+1)'(1)) ready_q[rl_q] <= 1'b0;
						found_q <= 1'b1;
						st_q <= wake_q ? ST_PUSH_HEAD :
							(cmd_q.op == OP_READY) ? ST_PUSH_HEAD :
							(cmd_q.op == OP_TICK) ? ST_SLICE_PUSH : ST_DONE;
					end else begin
						prev_q <= cur_q; hasp_q <= 1'b1;
						cur_q <= link_q[cur_q]; i_q <= i_q + 1'b1;
					end
				end
				ST_PUSH_HEAD: begin
					level_q[tsk_q] <= nl_q;
					if (count_q[nl_q] == '0) tail_q[nl_q] <= tsk_q;
					link_q[tsk_q] <= head_q[nl_q];
					head_q[nl_q] <= tsk_q;
					count_q[nl_q] <= count_q[nl_q] + 1'b1;
					ready_q[nl_q] <= 1'b1;
					if (wake_q) begin
						wake_q <= 1'b0;
						st_q <= (scan_q == TaskW'(NumTasks-1)) ? ST_SLICE : ST_TICK_SCAN;
						scan_q <= scan_q + 1'b1;
					end else st_q <= ST_DONE;
				end
				// one delay counter per cycle, pausing while a woken task is moved
				ST_TICK_SCAN: begin
					if (dflag_q[scan_q] && dleft_q[scan_q] <= 32'd1) begin
						dleft_q[scan_q] <= '0;
						dflag_q[scan_q] <= 1'b0;
						woken_q[scan_q] <= 1'b1;
						wake_q <= 1'b1;
						tsk_q <= scan_q; nl_q <= level_q[scan_q];
						rl_q <= level_q[scan_q]; cur_q <= head_q[level_q[scan_q]];
						hasp_q <= 1'b0; i_q <= '0;
						st_q <= ST_RM_WALK;
					end else begin
						if (dflag_q[scan_q]) dleft_q[scan_q] <= dleft_q[scan_q] - 32'd1;
						st_q <= (scan_q == TaskW'(NumTasks-1)) ? ST_SLICE : ST_TICK_SCAN;
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_SLICE: begin
					if (!runv_q) st_q <= ST_SCHED;
					else if (slice_q[run_q] <= 8'd1) begin
						slice_q[run_q] <= slen_q;
						tsk_q <= run_q; rl_q <= level_q[run_q];
						cur_q <= head_q[level_q[run_q]];
						hasp_q <= 1'b0; i_q <= '0;
						st_q <= ST_RM_WALK;
					end else begin
						slice_q[run_q] <= slice_q[run_q] - 8'd1;
						st_q <= ST_SCHED;
					end
				end
				ST_SLICE_PUSH: begin
					if (found_q) begin
						if (count_q[rl_q] == '0) head_q[rl_q] <= tsk_q;
						else link_q[tail_q[rl_q]] <= tsk_q;
						tail_q[rl_q] <= tsk_q;
						count_q[rl_q] <= count_q[rl_q] + 1'b1;
						ready_q[rl_q] <= 1'b1;
					end
					st_q <= ST_SCHED;
				end
				ST_SCHED: begin
					if (lock_q == '0 && ready_q != '0 &&
					    !(runv_q && head_q[top_lvl] == run_q)) begin
						run_q <= head_q[top_lvl];
						runv_q <= 1'b1;
						sw_q <= 1'b1;
					end
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					out_q.switch_now <= sw_q;
					out_q.next_task  <= run_q;
					out_q.woken_mask <= woken_q;
					out_q.lock_level <= lock_q;
					out_q.tick_total <= ticks_q;
					outv_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= st_d;
			endcase
		end
	end
endmodule
`default_nettype wire
